// File: sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	localparam int HUE_FRAC_BITS = 6;
	localparam int FRACTION_BITS = 8;

	localparam int HUE_W  = 15;
	localparam int FRAC_W = 9;
	localparam int CHAN_W = 8;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	localparam int ONE_UNIT    = 1 << FRACTION_BITS;
	localparam int SECTOR_SPAN = 60 << HUE_FRAC_BITS;
	localparam int SPAN_W      = $clog2(SECTOR_SPAN + 1);
	localparam int T_W         = $clog2(2 * SECTOR_SPAN);
	localparam int MAX_WRAPS   = ((1 << HUE_W) - 1) / (2 * SECTOR_SPAN);
	localparam int LAST_SECTOR = 5;

	localparam int INNER_W  = $clog2(ONE_UNIT * SECTOR_SPAN + 1);
	localparam int PROD_W   = INNER_W + FRAC_W;
	localparam int SCALED_W = PROD_W + 5;
	localparam int OUT_SHIFT = 2 * FRACTION_BITS + HUE_FRAC_BITS + 2;
	localparam int CHAN_MAX  = (1 << CHAN_W) - 1;

	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	typedef logic [CHAN_W-1:0] chan_t;

	// 255 / (60 * 2^(2F+H)) reduces to 17 / 2^(2F+H+2)
	function automatic chan_t chan_scale(input logic [PROD_W-1:0] prod);
		logic [SCALED_W-1:0] scaled;
		logic [SCALED_W-1:0] shr;
		scaled = (SCALED_W'(prod) << 4) + SCALED_W'(prod);
		shr = scaled >> OUT_SHIFT;
		if (shr > SCALED_W'(CHAN_MAX)) begin
			chan_scale = CHAN_W'(CHAN_MAX);
		end else begin
			chan_scale = shr[CHAN_W-1:0];
		end
	endfunction

endpackage

// File: sv/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

// hsv to rgb pixel converter
// slave channel s_axis_*: one pixel per transaction, tdata holds
//   hue [14:0] (1/64 degree), saturation [23:15] and value [32:24] (256 = 1.0),
//   alpha [40:33], zero padded to 48 bits
// master channel m_axis_*: one rgb pixel per transaction, tdata holds
//   red [7:0], green [15:8], blue [23:16], alpha [31:24]
// six register stages: hue folding and clamps, distance to sector center,
// chroma terms, value products, channel scaling, sector select into the
// output register
// throughput is one pixel per cycle while the receiver keeps accepting, set by the fully pipelined multipliers
// each stage has its own valid bit and advances when the next stage is empty
// or advancing, so bubbles are squeezed out and a stalled receiver only
// blocks input once all six stages hold pixels
// reset empties every stage; no pixel is lost or repeated under stalls
// saturation and value above 256 are clamped to 256, hue at or beyond
// 360 degrees lands in the last sector
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// hue, saturation, brightness_value, alpha_in, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// red, green, blue, alpha_out
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [HUE_W-1:0]  hue_in;
	logic [FRAC_W-1:0] sat_in;
	logic [FRAC_W-1:0] val_in;
	chan_t             alpha_in;

	logic en1, en2, en3, en4, en5, en6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [FRAC_W-1:0] sat_s1, sat_s2;
	logic [FRAC_W-1:0] val_s1, val_s2, val_s3;
	logic [T_W-1:0]    t_s1;
	logic [SPAN_W-1:0] kx_s2;
	logic [INNER_W-1:0] inx_s3, in0_s3;
	logic [PROD_W-1:0]  pc_s4, px_s4, p0_s4;
	chan_t cc_s5, cx_s5, c0_s5;
	sector_t sec_s1, sec_s2, sec_s3, sec_s4, sec_s5;
	chan_t alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;
	chan_t red_s6, green_s6, blue_s6, alpha_s6;

	logic [HUE_W-1:0]  t_full;
	sector_t           sec_d;
	logic [FRAC_W-1:0] sat_d, val_d;
	logic [T_W-1:0]    center_dist;
	logic [FRAC_W-1:0] sat_inv;
	chan_t             red_d, green_d, blue_d;

	assign hue_in   = s_axis_tdata[HUE_W-1:0];
	assign sat_in   = s_axis_tdata[HUE_W+FRAC_W-1:HUE_W];
	assign val_in   = s_axis_tdata[HUE_W+2*FRAC_W-1:HUE_W+FRAC_W];
	assign alpha_in = s_axis_tdata[HUE_W+2*FRAC_W+CHAN_W-1:HUE_W+2*FRAC_W];

	// stage advance chain
	assign en6 = !vld_s6 || m_axis_tready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_axis_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: hue mod two sectors, sector index, clamps
	always_comb begin
		t_full = hue_in;
		for (int j = 1; j <= MAX_WRAPS; j++) begin
			if (hue_in >= HUE_W'(j * 2 * SECTOR_SPAN)) begin
				t_full = hue_in - HUE_W'(j * 2 * SECTOR_SPAN);
			end
		end
		sec_d = SEC_R_Y;
		for (int i = 1; i <= LAST_SECTOR; i++) begin
			if (hue_in >= HUE_W'(i * SECTOR_SPAN)) begin
				sec_d = sector_t'(3'(i));
			end
		end
		sat_d = (sat_in > FRAC_W'(ONE_UNIT)) ? FRAC_W'(ONE_UNIT) : sat_in;
		val_d = (val_in > FRAC_W'(ONE_UNIT)) ? FRAC_W'(ONE_UNIT) : val_in;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1     <= t_full[T_W-1:0];
			sec_s1   <= sec_d;
			sat_s1   <= sat_d;
			val_s1   <= val_d;
			alpha_s1 <= alpha_in;
		end
	end

	// stage 2: weight of the secondary component
	assign center_dist = (t_s1 >= T_W'(SECTOR_SPAN)) ? t_s1 - T_W'(SECTOR_SPAN)
	                                                 : T_W'(SECTOR_SPAN) - t_s1;

	always_ff @(posedge clk) begin
		if (en2) begin
			kx_s2    <= SPAN_W'(T_W'(SECTOR_SPAN) - center_dist);
			sec_s2   <= sec_s1;
			sat_s2   <= sat_s1;
			val_s2   <= val_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// stage 3: s*k + (1-s)*span for the secondary and the zero channel
	assign sat_inv = FRAC_W'(ONE_UNIT) - sat_s2;

	always_ff @(posedge clk) begin
		if (en3) begin
			inx_s3   <= INNER_W'(sat_s2) * INNER_W'(kx_s2)
			          + INNER_W'(sat_inv) * INNER_W'(SECTOR_SPAN);
			in0_s3   <= INNER_W'(sat_inv) * INNER_W'(SECTOR_SPAN);
			sec_s3   <= sec_s2;
			val_s3   <= val_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	// stage 4: times value
	always_ff @(posedge clk) begin
		if (en4) begin
			pc_s4    <= PROD_W'(val_s3) * PROD_W'(ONE_UNIT * SECTOR_SPAN);
			px_s4    <= PROD_W'(val_s3) * PROD_W'(inx_s3);
			p0_s4    <= PROD_W'(val_s3) * PROD_W'(in0_s3);
			sec_s4   <= sec_s3;
			alpha_s4 <= alpha_s3;
		end
	end

	// stage 5: scale to 0..255
	always_ff @(posedge clk) begin
		if (en5) begin
			cc_s5    <= chan_scale(pc_s4);
			cx_s5    <= chan_scale(px_s4);
			c0_s5    <= chan_scale(p0_s4);
			sec_s5   <= sec_s4;
			alpha_s5 <= alpha_s4;
		end
	end

	// stage 6: sector select
	always_comb begin
		unique case (sec_s5)
			SEC_R_Y: begin
				red_d = cc_s5; green_d = cx_s5; blue_d = c0_s5;
			end
			SEC_Y_G: begin
				red_d = cx_s5; green_d = cc_s5; blue_d = c0_s5;
			end
			SEC_G_C: begin
				red_d = c0_s5; green_d = cc_s5; blue_d = cx_s5;
			end
			SEC_C_B: begin
				red_d = c0_s5; green_d = cx_s5; blue_d = cc_s5;
			end
			SEC_B_M: begin
				red_d = cx_s5; green_d = c0_s5; blue_d = cc_s5;
			end
			default: begin
				red_d = cc_s5; green_d = c0_s5; blue_d = cx_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			red_s6   <= red_d;
			green_s6 <= green_d;
			blue_s6  <= blue_d;
			alpha_s6 <= alpha_s5;
		end
	end

	assign m_axis_tvalid = vld_s6;
	assign m_axis_tdata  = {alpha_s6, blue_s6, green_s6, red_s6};

`ifndef SYNTHESIS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (cc_s5 >= cx_s5) && (cx_s5 >= c0_s5))
		else $error("channel ordering broken");

	a_kx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> kx_s2 <= SPAN_W'(SECTOR_SPAN))
		else $error("secondary weight out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5
		                   && vld_s6 && !m_axis_tready)
		else $error("input blocked while pipeline has room");

	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !en6 |=> vld_s5 && $stable(cx_s5) && $stable(sec_s5))
		else $error("stage 5 lost data under stall");
`endif

endmodule
